FILE: sv/grid_ray_dda_caster_defines.svh
// assertion macros shared by the ray caster rtl
`ifndef GRID_RAY_DDA_CASTER_DEFINES_SVH
`define GRID_RAY_DDA_CASTER_DEFINES_SVH

// same-cycle implication on clock, disabled while reset is high
`define GRDC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on clock, disabled while reset is high
`define GRDC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/grdc_pkg.sv
// types and constants of the grid ray caster
package grdc_pkg;

   typedef logic [5:0]        coord_type;
   typedef logic [31:0]       dist_type;
   typedef logic [11:0]       height_type;
   typedef logic signed [1:0] step_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_STEP  = 6'b000010,
      ST_CHECK = 6'b000100,
      ST_PERP  = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   localparam logic       OP_WRITE    = 1'b0;
   localparam logic       OP_CAST     = 1'b1;
   localparam logic [1:0] KIND_WALL   = 2'd1;
   localparam logic [1:0] KIND_DOOR   = 2'd2;
   localparam dist_type   PERP_FLOOR  = 32'd6554;
   localparam height_type WIN_RESET   = 12'd480;
   localparam int         DIV_STEPS   = 28;
   localparam int         DIV_CNT_W   = 5;

endpackage

FILE: sv/grid_ray_dda_caster.sv
// grid ray caster: map memory, dda stepping sequencer and slice divider
//
// A write beat stores one cell. A cast beat does, for each of up to
// 2*MAP_SIDE cell moves, a step with map read and then a cell test; it then
// forms the perpendicular distance, runs a restoring division with a 28-bit
// quotient for the slice height and launches the result once the output
// register is free. The sequencing is set by the single map read port and
// the one shared 33-bit subtractor that serves the axis compare, the distance
// difference and the divider. req_ready is high only while the sequencer is
// idle; a finished result waits in the output register while the next beat
// is taken. The MAP_SIDE*MAP_SIDE x 5 map has no clearing: a cell must be
// written before any ray reads it.
`include "grid_ray_dda_caster_defines.svh"

module grid_ray_dda_caster #(
   parameter int MAP_SIDE    = 64,
   parameter int DOOR_FRAMES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  grdc_pkg::height_type  csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  grdc_pkg::coord_type   req_cell_x,
   input  grdc_pkg::coord_type   req_cell_y,
   input  logic [1:0]            req_cell_kind,
   input  logic [2:0]            req_door_frame,
   input  grdc_pkg::step_type    req_step_x,
   input  grdc_pkg::step_type    req_step_y,
   input  grdc_pkg::dist_type    req_side_dist_x,
   input  grdc_pkg::dist_type    req_side_dist_y,
   input  grdc_pkg::dist_type    req_delta_dist_x,
   input  grdc_pkg::dist_type    req_delta_dist_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output grdc_pkg::coord_type   rsp_hit_x,
   output grdc_pkg::coord_type   rsp_hit_y,
   output logic                  rsp_hit_side,
   output grdc_pkg::dist_type    rsp_perp_distance,
   output logic [15:0]           rsp_slice_height,
   output grdc_pkg::height_type  rsp_span_top,
   output grdc_pkg::height_type  rsp_span_bottom,
   output logic                  rsp_left_map
);
   import grdc_pkg::*;

   localparam int AW         = $clog2(MAP_SIDE);
   localparam int IDX_W      = (AW > 6) ? AW : 6;
   localparam int POS_W      = IDX_W + 2;
   localparam int DEPTH      = MAP_SIDE * MAP_SIDE;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int STEP_LIMIT = 2 * MAP_SIDE;
   localparam int MOVE_W     = $clog2(STEP_LIMIT + 1);
   localparam logic signed [POS_W-1:0] MAP_LIM = POS_W'(MAP_SIDE);
   localparam logic signed [POS_W-1:0] MAP_MAX = POS_W'(MAP_SIDE - 1);
   localparam logic [4:0]              FRAME_LIM = 5'(DOOR_FRAMES);

   function automatic logic in_map(input logic signed [POS_W-1:0] px,
                                   input logic signed [POS_W-1:0] py);
      return (px >= 0) && (px < MAP_LIM) && (py >= 0) && (py < MAP_LIM);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] px,
                                                   input logic [POS_W-1:0] py);
      return ADDR_W'(py) * ADDR_W'(MAP_SIDE) + ADDR_W'(px);
   endfunction

   function automatic dist_type sat_add(input dist_type a, input dist_type b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? '1 : s[31:0];
   endfunction

   function automatic logic [POS_W-1:0] clamp_pos(input logic signed [POS_W-1:0] p);
      if (p < 0) begin
         return '0;
      end else if (p > MAP_MAX) begin
         return MAP_MAX;
      end
      return p;
   endfunction

   // map storage
   logic [4:0]        map_mem_ff [DEPTH];
   logic [4:0]        rd_cell_ff;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;

   // sequencer and datapath registers
   state_type                state_ff, state_in;
   height_type               win_h_ff;
   logic signed [POS_W-1:0]  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   step_type                 stp_x_ff, stp_x_in, stp_y_ff, stp_y_in;
   dist_type                 sd_x_ff, sd_x_in, sd_y_ff, sd_y_in;
   dist_type                 dd_x_ff, dd_x_in, dd_y_ff, dd_y_in;
   logic [MOVE_W-1:0]        moves_ff, moves_in;
   logic                     side_ff, side_in, left_ff, left_in;
   dist_type                 perp_ff, perp_in;
   dist_type                 rem_ff, rem_in;
   logic [DIV_STEPS-1:0]     dvd_ff, dvd_in;
   logic [DIV_CNT_W-1:0]     cnt_ff, cnt_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   coord_type   rsp_hit_x_ff, rsp_hit_x_in, rsp_hit_y_ff, rsp_hit_y_in;
   logic        rsp_hit_side_ff, rsp_hit_side_in, rsp_left_ff, rsp_left_in;
   dist_type    rsp_perp_ff, rsp_perp_in;
   logic [15:0] rsp_lh_ff, rsp_lh_in;
   height_type  rsp_ds_ff, rsp_ds_in, rsp_de_ff, rsp_de_in;

   // shared subtractor
   logic [32:0] sub_a, sub_b, sub_d;
   logic        sub_borrow;

   logic                    accept, slot_free, cell_hit, move_x;
   logic signed [POS_W-1:0] nx, ny;
   logic [32:0]             rem_shift;
   logic [POS_W-1:0]        clamp_x, clamp_y;
   logic [15:0]             lh_sat;
   logic [10:0]             half;
   logic [14:0]             lh_half;
   logic [15:0]             de_sum;
   height_type              h_m1;
   dist_type                perp_raw;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign wr_en     = accept && (req_op == OP_WRITE) &&
                      in_map(POS_W'(req_cell_x), POS_W'(req_cell_y));

   assign sub_d      = sub_a - sub_b;
   assign sub_borrow = sub_d[32];
   assign rem_shift  = {rem_ff, dvd_ff[DIV_STEPS-1]};

   always_comb begin
      case (state_ff)
         ST_STEP: begin
            sub_a = {1'b0, sd_x_ff};
            sub_b = {1'b0, sd_y_ff};
         end
         ST_PERP: begin
            sub_a = side_ff ? {1'b0, sd_y_ff} : {1'b0, sd_x_ff};
            sub_b = side_ff ? {1'b0, dd_y_ff} : {1'b0, dd_x_ff};
         end
         ST_DIV: begin
            sub_a = rem_shift;
            sub_b = {1'b0, perp_ff};
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
   end

   // sdx < sdy picks a column move
   assign move_x = sub_borrow;
   assign nx = move_x ? pos_x_ff + {{(POS_W-2){stp_x_ff[1]}}, stp_x_ff} : pos_x_ff;
   assign ny = move_x ? pos_y_ff : pos_y_ff + {{(POS_W-2){stp_y_ff[1]}}, stp_y_ff};
   assign rd_addr = cell_addr(nx, ny);

   assign cell_hit = (rd_cell_ff[1:0] == KIND_WALL) ||
                     ((rd_cell_ff[1:0] == KIND_DOOR) &&
                      ((5'(rd_cell_ff[4:2]) + 5'd1) < FRAME_LIM));

   assign perp_raw = (sub_borrow || sub_d[31:0] == '0) ? '0 : sub_d[31:0];

   // slice geometry from the finished quotient
   assign lh_sat  = (dvd_ff[DIV_STEPS-1:16] != '0) ? 16'hFFFF : dvd_ff[15:0];
   assign half    = win_h_ff[11:1];
   assign lh_half = lh_sat[15:1];
   assign de_sum  = 16'(half) + 16'(lh_half);
   assign h_m1    = win_h_ff - 12'd1;
   assign clamp_x = clamp_pos(pos_x_ff);
   assign clamp_y = clamp_pos(pos_y_ff);

   always_comb begin
      state_in = state_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      stp_x_in = stp_x_ff;
      stp_y_in = stp_y_ff;
      sd_x_in  = sd_x_ff;
      sd_y_in  = sd_y_ff;
      dd_x_in  = dd_x_ff;
      dd_y_in  = dd_y_ff;
      moves_in = moves_ff;
      side_in  = side_ff;
      left_in  = left_ff;
      perp_in  = perp_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      cnt_in   = cnt_ff;
      rd_en    = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_hit_x_in    = rsp_hit_x_ff;
      rsp_hit_y_in    = rsp_hit_y_ff;
      rsp_hit_side_in = rsp_hit_side_ff;
      rsp_left_in     = rsp_left_ff;
      rsp_perp_in     = rsp_perp_ff;
      rsp_lh_in       = rsp_lh_ff;
      rsp_ds_in       = rsp_ds_ff;
      rsp_de_in       = rsp_de_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == OP_CAST) begin
               pos_x_in = POS_W'(req_cell_x);
               pos_y_in = POS_W'(req_cell_y);
               stp_x_in = req_step_x;
               stp_y_in = req_step_y;
               sd_x_in  = req_side_dist_x;
               sd_y_in  = req_side_dist_y;
               dd_x_in  = req_delta_dist_x;
               dd_y_in  = req_delta_dist_y;
               moves_in = '0;
               side_in  = 1'b0;
               if (in_map(POS_W'(req_cell_x), POS_W'(req_cell_y))) begin
                  left_in  = 1'b0;
                  state_in = ST_STEP;
               end else begin
                  left_in  = 1'b1;
                  state_in = ST_PERP;
               end
            end
         end
         ST_STEP: begin
            if (moves_ff >= MOVE_W'(STEP_LIMIT)) begin
               left_in  = 1'b1;
               state_in = ST_PERP;
            end else begin
               moves_in = moves_ff + MOVE_W'(1);
               pos_x_in = nx;
               pos_y_in = ny;
               side_in  = !move_x;
               if (move_x) begin
                  sd_x_in = sat_add(sd_x_ff, dd_x_ff);
               end else begin
                  sd_y_in = sat_add(sd_y_ff, dd_y_ff);
               end
               if (in_map(nx, ny)) begin
                  rd_en    = 1'b1;
                  state_in = ST_CHECK;
               end else begin
                  left_in  = 1'b1;
                  state_in = ST_PERP;
               end
            end
         end
         ST_CHECK: begin
            state_in = cell_hit ? ST_PERP : ST_STEP;
         end
         ST_PERP: begin
            perp_in  = (moves_ff == '0 || perp_raw == '0) ? PERP_FLOOR : perp_raw;
            rem_in   = '0;
            dvd_in   = {win_h_ff, 16'd0};
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // one restoring division bit per cycle
            rem_in = sub_borrow ? rem_shift[31:0] : sub_d[31:0];
            dvd_in = {dvd_ff[DIV_STEPS-2:0], !sub_borrow};
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_hit_x_in    = clamp_x[5:0];
               rsp_hit_y_in    = clamp_y[5:0];
               rsp_hit_side_in = side_ff;
               rsp_left_in     = left_ff;
               rsp_perp_in     = perp_ff;
               rsp_lh_in       = lh_sat;
               rsp_ds_in       = (15'(half) <= lh_half) ? '0 : 12'(half - lh_half[10:0]);
               if (win_h_ff == '0) begin
                  rsp_de_in = '0;
               end else if (de_sum > 16'(h_m1)) begin
                  rsp_de_in = h_m1;
               end else begin
                  rsp_de_in = de_sum[11:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem_ff[cell_addr(POS_W'(req_cell_x), POS_W'(req_cell_y))] <=
            {req_door_frame, req_cell_kind};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_cell_ff <= map_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_h_ff     <= WIN_RESET;
         rsp_valid_ff <= 1'b0;
         moves_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         moves_ff     <= moves_in;
         if (csr_we) begin
            win_h_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff        <= pos_x_in;
      pos_y_ff        <= pos_y_in;
      stp_x_ff        <= stp_x_in;
      stp_y_ff        <= stp_y_in;
      sd_x_ff         <= sd_x_in;
      sd_y_ff         <= sd_y_in;
      dd_x_ff         <= dd_x_in;
      dd_y_ff         <= dd_y_in;
      side_ff         <= side_in;
      left_ff         <= left_in;
      perp_ff         <= perp_in;
      rem_ff          <= rem_in;
      dvd_ff          <= dvd_in;
      cnt_ff          <= cnt_in;
      rsp_hit_x_ff    <= rsp_hit_x_in;
      rsp_hit_y_ff    <= rsp_hit_y_in;
      rsp_hit_side_ff <= rsp_hit_side_in;
      rsp_left_ff     <= rsp_left_in;
      rsp_perp_ff     <= rsp_perp_in;
      rsp_lh_ff       <= rsp_lh_in;
      rsp_ds_ff       <= rsp_ds_in;
      rsp_de_ff       <= rsp_de_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit_x         = rsp_hit_x_ff;
   assign rsp_hit_y         = rsp_hit_y_ff;
   assign rsp_hit_side      = rsp_hit_side_ff;
   assign rsp_perp_distance = rsp_perp_ff;
   assign rsp_slice_height  = rsp_lh_ff;
   assign rsp_span_top      = rsp_ds_ff;
   assign rsp_span_bottom   = rsp_de_ff;
   assign rsp_left_map      = rsp_left_ff;

   `GRDC_ASSERT_NOW(a_div_nonzero, state_ff == ST_DIV, perp_ff != '0, "zero divisor")
   `GRDC_ASSERT_NOW(a_move_limit, 1'b1, moves_ff <= MOVE_W'(STEP_LIMIT), "move count over limit")
   `GRDC_ASSERT_NEXT(a_write_beat, accept && req_op == OP_WRITE, req_ready, "write not idle")
   `GRDC_ASSERT_NEXT(a_launch, state_ff == ST_FIN && slot_free, rsp_valid_ff && req_ready, "no launch")
   `GRDC_ASSERT_NOW(a_span_order, rsp_valid_ff, rsp_ds_ff <= rsp_de_ff, "draw span reversed")

endmodule

FILE: test/tb_top.sv
// self-checking testbench for the grid ray caster: directed table, then random phases
`timescale 1ns / 1ps

module tb_top;
   import grdc_pkg::*;

   localparam int MAP_SIDE    = 64;
   localparam int DOOR_FRAMES = 8;
   localparam int STALL_LIMIT = 2000;
   localparam int CFG_SETTLE  = 8;
   localparam int TAIL_CYCLES = 40;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 60;
   localparam int MAX_REPORTS = 50;

   localparam logic [1:0] KIND_EMPTY = 2'd0;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   localparam step_type STEP_POS  = 2'b01;
   localparam step_type STEP_NEG  = 2'b11;
   localparam step_type STEP_HOLD = 2'b00;
   localparam step_type STEP_SKIP = 2'b10;

   localparam dist_type Q_ONE  = 32'h0001_0000;
   localparam dist_type Q_HALF = 32'h0000_8000;
   localparam dist_type Q_MAX  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic       op;
      coord_type  cx;
      coord_type  cy;
      logic [1:0] kind;
      logic [2:0] frame;
      step_type   sx;
      step_type   sy;
      dist_type   sdx;
      dist_type   sdy;
      dist_type   ddx;
      dist_type   ddy;
   } grid_req_type;

   typedef struct packed {
      coord_type   hx;
      coord_type   hy;
      logic        side;
      dist_type    perp;
      logic [15:0] lh;
      height_type  ds;
      height_type  de;
      logic        left;
   } slice_type;

   typedef struct packed {
      grid_req_type req;
      logic         typed;
      slice_type    want;
   } plan_row_type;

   localparam slice_type NO_SLICE = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   height_type  csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = OP_WRITE;
   coord_type   req_cell_x = '0;
   coord_type   req_cell_y = '0;
   logic [1:0]  req_cell_kind = KIND_EMPTY;
   logic [2:0]  req_door_frame = '0;
   step_type    req_step_x = STEP_HOLD;
   step_type    req_step_y = STEP_HOLD;
   dist_type    req_side_dist_x = '0;
   dist_type    req_side_dist_y = '0;
   dist_type    req_delta_dist_x = '0;
   dist_type    req_delta_dist_y = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   coord_type   rsp_hit_x;
   coord_type   rsp_hit_y;
   logic        rsp_hit_side;
   dist_type    rsp_perp_distance;
   logic [15:0] rsp_slice_height;
   height_type  rsp_span_top;
   height_type  rsp_span_bottom;
   logic        rsp_left_map;

   // mirror of the map and the height register
   logic [4:0] cell_mem [MAP_SIDE*MAP_SIDE];
   bit         cell_set [MAP_SIDE*MAP_SIDE];
   height_type win = WIN_RESET;
   slice_type  slice_q [$];

   int err_cnt    = 0;
   int n_writes   = 0;
   int n_casts    = 0;
   int n_results  = 0;
   int n_left     = 0;
   int n_heights  = 0;
   int wall_share = 45;
   int rsp_hold   = 0;
   int stall_cycles = 0;
   bit calm = 1'b0;

   grid_ray_dda_caster #(
      .MAP_SIDE    (MAP_SIDE),
      .DOOR_FRAMES (DOOR_FRAMES)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_cell_x        (req_cell_x),
      .req_cell_y        (req_cell_y),
      .req_cell_kind     (req_cell_kind),
      .req_door_frame    (req_door_frame),
      .req_step_x        (req_step_x),
      .req_step_y        (req_step_y),
      .req_side_dist_x   (req_side_dist_x),
      .req_side_dist_y   (req_side_dist_y),
      .req_delta_dist_x  (req_delta_dist_x),
      .req_delta_dist_y  (req_delta_dist_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit_x         (rsp_hit_x),
      .rsp_hit_y         (rsp_hit_y),
      .rsp_hit_side      (rsp_hit_side),
      .rsp_perp_distance (rsp_perp_distance),
      .rsp_slice_height  (rsp_slice_height),
      .rsp_span_top      (rsp_span_top),
      .rsp_span_bottom   (rsp_span_bottom),
      .rsp_left_map      (rsp_left_map)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int clamp_cell(int v);
      if (v < 0) return 0;
      if (v > MAP_SIDE - 1) return MAP_SIDE - 1;
      return v;
   endfunction

   // walks the ray over the mirrored map; miss is the first unwritten cell read, or -1
   function automatic slice_type trace_ray(input grid_req_type r, output int miss);
      int          mx, my, sx, sy, moves, idx;
      logic        side, left;
      logic [32:0] acc;
      dist_type    sdx, sdy, perp;
      logic [4:0]  c;
      logic [63:0] lh, half, ds, de;
      slice_type   s;
      mx = int'(r.cx);
      my = int'(r.cy);
      sx = $signed(r.sx);
      sy = $signed(r.sy);
      sdx = r.sdx;
      sdy = r.sdy;
      miss = -1;
      side = 1'b0;
      left = 1'b0;
      moves = 0;
      forever begin
         if (moves >= 2 * MAP_SIDE) begin
            left = 1'b1;
            break;
         end
         moves++;
         if (sdx < sdy) begin
            acc = {1'b0, sdx} + {1'b0, r.ddx};
            sdx = acc[32] ? Q_MAX : acc[31:0];
            mx += sx;
            side = 1'b0;
         end else begin
            acc = {1'b0, sdy} + {1'b0, r.ddy};
            sdy = acc[32] ? Q_MAX : acc[31:0];
            my += sy;
            side = 1'b1;
         end
         if (mx < 0 || mx >= MAP_SIDE || my < 0 || my >= MAP_SIDE) begin
            left = 1'b1;
            break;
         end
         idx = my * MAP_SIDE + mx;
         if (!cell_set[idx]) begin
            miss = idx;
            break;
         end
         c = cell_mem[idx];
         if (c[1:0] == KIND_WALL) break;
         if (c[1:0] == KIND_DOOR && int'(c[4:2]) < DOOR_FRAMES - 1) break;
      end
      if (moves == 0) perp = '0;
      else if (side == 1'b0) perp = (sdx > r.ddx) ? sdx - r.ddx : '0;
      else perp = (sdy > r.ddy) ? sdy - r.ddy : '0;
      if (perp == '0) perp = PERP_FLOOR;
      lh = (64'(win) << 16) / 64'(perp);
      if (lh > 64'd65535) lh = 64'd65535;
      half = 64'(win) / 2;
      ds = (lh / 2 >= half) ? 64'd0 : half - lh / 2;
      de = half + lh / 2;
      if (win == '0) de = 64'd0;
      else if (de > 64'(win) - 1) de = 64'(win) - 1;
      s.hx = 6'(clamp_cell(mx));
      s.hy = 6'(clamp_cell(my));
      s.side = side;
      s.perp = perp;
      s.lh = lh[15:0];
      s.ds = ds[11:0];
      s.de = de[11:0];
      s.left = left;
      return s;
   endfunction

   function automatic slice_type slice_of(int x, int y, logic side, dist_type perp,
                                          int lh, int ds, int de, logic left);
      slice_type s;
      s.hx = 6'(x);
      s.hy = 6'(y);
      s.side = side;
      s.perp = perp;
      s.lh = 16'(lh);
      s.ds = 12'(ds);
      s.de = 12'(de);
      s.left = left;
      return s;
   endfunction

   // unused fields of a write still carry random values
   function automatic grid_req_type cell_wr(int x, int y, logic [1:0] k, logic [2:0] f);
      grid_req_type r;
      r.op = OP_WRITE;
      r.cx = 6'(x);
      r.cy = 6'(y);
      r.kind = k;
      r.frame = f;
      r.sx = 2'($urandom);
      r.sy = 2'($urandom);
      r.sdx = $urandom;
      r.sdy = $urandom;
      r.ddx = $urandom;
      r.ddy = $urandom;
      return r;
   endfunction

   function automatic grid_req_type ray(int x, int y, step_type sx, step_type sy,
                                        dist_type sdx, dist_type sdy,
                                        dist_type ddx, dist_type ddy);
      grid_req_type r;
      r.op = OP_CAST;
      r.cx = 6'(x);
      r.cy = 6'(y);
      r.kind = 2'($urandom);
      r.frame = 3'($urandom);
      r.sx = sx;
      r.sy = sy;
      r.sdx = sdx;
      r.sdy = sdy;
      r.ddx = ddx;
      r.ddy = ddy;
      return r;
   endfunction

   function automatic grid_req_type rand_cell_wr(int x, int y);
      int         pick;
      logic [1:0] k;
      pick = $urandom_range(0, 99);
      if (pick < wall_share) k = KIND_WALL;
      else if (pick < wall_share + 20) k = KIND_DOOR;
      else if (pick < wall_share + 25) k = KIND_SPARE;
      else k = KIND_EMPTY;
      return cell_wr(x, y, k, 3'($urandom));
   endfunction

   function automatic int draw_wait();
      return calm ? 0 : int'($urandom_range(0, 12));
   endfunction

   task automatic check_field(input string tag, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         err_cnt++;
         if (err_cnt <= MAX_REPORTS)
            $display("%0t %s mismatch: expected %0h, actual %0h", $time, tag, want, got);
      end
   endtask

   // one beat on the request side; the mirror is updated when the beat is taken
   task automatic put_beat(input grid_req_type r, input logic typed, input slice_type want);
      int        gap;
      int        miss;
      slice_type s;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op <= r.op;
      req_cell_x <= r.cx;
      req_cell_y <= r.cy;
      req_cell_kind <= r.kind;
      req_door_frame <= r.frame;
      req_step_x <= r.sx;
      req_step_y <= r.sy;
      req_side_dist_x <= r.sdx;
      req_side_dist_y <= r.sdy;
      req_delta_dist_x <= r.ddx;
      req_delta_dist_y <= r.ddy;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (r.op == OP_WRITE) begin
         cell_mem[int'(r.cy) * MAP_SIDE + int'(r.cx)] = {r.frame, r.kind};
         cell_set[int'(r.cy) * MAP_SIDE + int'(r.cx)] = 1'b1;
         n_writes++;
      end else begin
         s = trace_ray(r, miss);
         slice_q.push_back(typed ? want : s);
         n_casts++;
      end
   endtask

   // writes every unwritten cell the ray would read, then casts it
   task automatic cast_ray(input grid_req_type r, input logic typed, input slice_type want);
      int        miss;
      slice_type s;
      s = trace_ray(r, miss);
      while (miss >= 0) begin
         put_beat(rand_cell_wr(miss % MAP_SIDE, miss / MAP_SIDE), 1'b0, NO_SLICE);
         s = trace_ray(r, miss);
      end
      put_beat(r, typed, want);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (slice_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_height(input height_type h);
      drain();
      repeat (CFG_SETTLE) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
      win = h;
      n_heights++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         rsp_hold = draw_wait();
         rsp_ready <= (rsp_hold == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= (rsp_hold == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : slice_check
      slice_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (rsp_left_map === 1'b1) n_left++;
         if (slice_q.size() == 0) begin
            err_cnt++;
            $display("%0t result beat with nothing pending: hit %0d,%0d", $time,
                     rsp_hit_x, rsp_hit_y);
         end else begin
            want = slice_q.pop_front();
            check_field("hit_x", 32'(want.hx), 32'(rsp_hit_x));
            check_field("hit_y", 32'(want.hy), 32'(rsp_hit_y));
            check_field("hit_side", 32'(want.side), 32'(rsp_hit_side));
            check_field("perp_distance", want.perp, rsp_perp_distance);
            check_field("slice_height", 32'(want.lh), 32'(rsp_slice_height));
            check_field("span_top", 32'(want.ds), 32'(rsp_span_top));
            check_field("span_bottom", 32'(want.de), 32'(rsp_span_bottom));
            check_field("left_map", 32'(want.left), 32'(rsp_left_map));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t no beat moved for %0d cycles", $time, stall_cycles);
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      plan_row_type plan [$];
      int           ph, i, m;
      height_type   h;
      step_type     sx, sy;
      dist_type     sdx, sdy, dx, dy;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset height 480; distances of one cell give a full-height slice
      plan.push_back(plan_row_type'{cell_wr(1, 0, KIND_WALL, 3'd0), 1'b0, NO_SLICE});
      plan.push_back(plan_row_type'{ray(0, 0, STEP_POS, STEP_POS, Q_ONE, Q_MAX, Q_ONE, Q_ONE),
                                    1'b1, slice_of(1, 0, 1'b0, Q_ONE, 480, 0, 479, 1'b0)});
      // leaving the map on the left, top and right edges, zero distance floors to 0.1
      plan.push_back(plan_row_type'{ray(0, 0, STEP_NEG, STEP_POS, 32'd0, Q_MAX, Q_ONE, Q_ONE),
                                    1'b1, slice_of(0, 0, 1'b0, PERP_FLOOR, 4799, 0, 479, 1'b1)});
      plan.push_back(plan_row_type'{ray(5, 0, STEP_POS, STEP_NEG, Q_MAX, 32'd0, Q_ONE, Q_ONE),
                                    1'b1, slice_of(5, 0, 1'b1, PERP_FLOOR, 4799, 0, 479, 1'b1)});
      plan.push_back(plan_row_type'{ray(63, 63, STEP_POS, STEP_POS, 32'd0, Q_MAX, Q_ONE, Q_ONE),
                                    1'b1,
                                    slice_of(63, 63, 1'b0, PERP_FLOOR, 4799, 0, 479, 1'b1)});
      // wall at the start is skipped, open door passes, closing door stops
      plan.push_back(plan_row_type'{cell_wr(9, 10, KIND_WALL, 3'd3), 1'b0, NO_SLICE});
      plan.push_back(plan_row_type'{cell_wr(10, 10, KIND_DOOR, 3'd7), 1'b0, NO_SLICE});
      plan.push_back(plan_row_type'{cell_wr(11, 10, KIND_DOOR, 3'd6), 1'b0, NO_SLICE});
      plan.push_back(plan_row_type'{ray(9, 10, STEP_POS, STEP_POS, 32'd0, Q_MAX, Q_ONE, Q_ONE),
                                    1'b1, slice_of(11, 10, 1'b0, Q_ONE, 480, 0, 479, 1'b0)});
      // zero step never leaves: step limit
      plan.push_back(plan_row_type'{cell_wr(30, 30, KIND_EMPTY, 3'd0), 1'b0, NO_SLICE});
      plan.push_back(plan_row_type'{ray(30, 30, STEP_HOLD, STEP_POS, 32'd0, Q_MAX, 32'd0, Q_ONE),
                                    1'b1,
                                    slice_of(30, 30, 1'b0, PERP_FLOOR, 4799, 0, 479, 1'b1)});
      // unused kind behaves as empty
      plan.push_back(plan_row_type'{cell_wr(12, 10, KIND_SPARE, 3'd5), 1'b0, NO_SLICE});
      plan.push_back(plan_row_type'{cell_wr(13, 10, KIND_WALL, 3'd0), 1'b0, NO_SLICE});
      plan.push_back(plan_row_type'{ray(11, 10, STEP_POS, STEP_POS, 32'd0, Q_MAX, Q_ONE, Q_ONE),
                                    1'b0, NO_SLICE});
      plan.push_back(plan_row_type'{cell_wr(20, 20, KIND_DOOR, 3'd0), 1'b0, NO_SLICE});
      plan.push_back(plan_row_type'{ray(20, 21, STEP_POS, STEP_NEG, Q_MAX, Q_HALF, Q_ONE, Q_ONE),
                                    1'b0, NO_SLICE});
      // step of -2, saturating sums, far wall, both steps zero on a wall
      plan.push_back(plan_row_type'{ray(40, 40, STEP_SKIP, STEP_HOLD, 32'h4000, 32'h2_0000,
                                        Q_HALF, Q_HALF), 1'b0, NO_SLICE});
      plan.push_back(plan_row_type'{ray(32, 32, STEP_POS, STEP_POS, 32'hFFFF_0000, Q_MAX,
                                        Q_MAX, Q_MAX), 1'b0, NO_SLICE});
      plan.push_back(plan_row_type'{ray(50, 5, STEP_NEG, STEP_POS, 32'h7FFF_0000, 32'h7FFF_8000,
                                        32'h00FF_0000, 32'h00FF_0000), 1'b0, NO_SLICE});
      plan.push_back(plan_row_type'{cell_wr(45, 45, KIND_WALL, 3'd0), 1'b0, NO_SLICE});
      plan.push_back(plan_row_type'{ray(45, 45, STEP_HOLD, STEP_HOLD, 32'd0, 32'd0, 32'd0, 32'd0),
                                    1'b0, NO_SLICE});

      for (i = 0; i < plan.size(); i++) begin
         if (plan[i].req.op == OP_CAST)
            cast_ray(plan[i].req, plan[i].typed, plan[i].want);
         else
            put_beat(plan[i].req, 1'b0, NO_SLICE);
      end

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: h = 12'd4095;
            1: h = 12'd2;
            2: h = 12'd0;
            3: h = 12'd1;
            default: h = 12'($urandom_range(2, 4095));
         endcase
         set_height(h);
         // alternate dense and sparse maps so some rays travel far
         wall_share = (ph % 2) ? 15 : 45;
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 59) == 0) drain();
            if ($urandom_range(0, 3) == 0) begin
               put_beat(rand_cell_wr($urandom_range(0, 63), $urandom_range(0, 63)),
                        1'b0, NO_SLICE);
            end else begin
               sx = ($urandom_range(0, 9) == 0) ? step_type'(2'($urandom)) :
                    ($urandom_range(0, 1) ? STEP_POS : STEP_NEG);
               sy = ($urandom_range(0, 9) == 0) ? step_type'(2'($urandom)) :
                    ($urandom_range(0, 1) ? STEP_POS : STEP_NEG);
               dx = $urandom_range(32'h4000, 32'h10_0000);
               dy = $urandom_range(32'h4000, 32'h10_0000);
               sdx = $urandom_range(0, dx);
               sdy = $urandom_range(0, dy);
               m = $urandom_range(0, 19);
               if (m == 0) begin
                  dx = $urandom;
                  dy = $urandom;
                  sdx = $urandom;
                  sdy = $urandom;
               end else if (m == 1) begin
                  dx = Q_MAX;
                  sdx = Q_MAX;
               end else if (m == 2) begin
                  dy = Q_MAX;
                  sdy = Q_MAX;
               end
               cast_ray(ray($urandom_range(0, 63), $urandom_range(0, 63), sx, sy,
                            sdx, sdy, dx, dy), 1'b0, NO_SLICE);
            end
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d cell writes and %0d rays over %0d window heights",
               n_writes, n_casts, n_heights + 1);
      $display("%0d slices checked, %0d stopped off the map or at the step limit",
               n_results, n_left);
      if (err_cnt == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

FILE: files.f
+incdir+sv
sv/grdc_pkg.sv
sv/grid_ray_dda_caster.sv
test/tb_top.sv
